>>> sv/dht_pkg.sv
// Shared types and constants for the double hashing counting table.
package dht_pkg;

  // Default sizes of the table, the key and the per-slot count.
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int KEY_BITS_DEF    = 17;
  localparam int COUNT_BITS_DEF  = 24;

  // Fixed field widths.
  localparam int CFG_W   = 11;
  localparam int ENTRY_W = 11;
  localparam int IDX_W   = 10;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int MARK_W  = 2;

  // Size register reset value and the smallest size in use.
  localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1021;
  localparam logic [CFG_W-1:0] SIZE_MIN   = 11'd3;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_COUNT  = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // Slot marks; empty must encode as zero so the clearing sweep writes zeros.
  typedef enum logic [MARK_W-1:0] {
    MARK_EMPTY    = 2'd0,
    MARK_OCCUPIED = 2'd1,
    MARK_REMOVED  = 2'd2
  } mark_t;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_HASH,
    S_STEP,
    S_CHK,
    S_OUT
  } dht_state_t;

endpackage

>>> sv/dht_mod_unit.sv
// Restoring remainder unit, one quotient bit per cycle.
module dht_mod_unit #(
  parameter int DIVIDEND_W = 17,
  parameter int DIVISOR_W  = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVISOR_W-1:0]  remainder
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DIVIDEND_W-1:0] dvd_r, dvd_nxt;
  logic [DIVISOR_W-1:0]  div_r, div_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W:0]    trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[DIVIDEND_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIVIDEND_W);
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // The partial remainder stays below the divisor, so the trial fits.
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = DIVISOR_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[DIVISOR_W-1:0];
      end
      dvd_nxt = {dvd_r[DIVIDEND_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

>>> sv/dht_slot_ram.sv
// Slot store: one write port and one registered read port.
module dht_slot_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 43
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/double_hash_counting_table.sv
// Top level of the double hashing counting table.
//
//  Port group   Direction  Handshake              Contents
//  in_*         input      in_valid / in_stall    opcode, key
//  out_*        output     out_valid / out_stall  status, vote_count, slot,
//                                                 new_entry, entry_index
//  cfg_*        input      cfg_wr_en              table_size (write only)
//
// One transaction is worked at a time. Its key passes through the bit-serial
// key modulo unit, the probe step is formed, the slot memory read port is
// read once per probe, and the result is loaded into the output register;
// the next transaction is taken after the return to idle. After reset the
// slot memory is swept clear, one slot a cycle, with in_stall high. A result
// waiting on out_stall does not hold off the next input transaction, but the
// result of that transaction waits until the output register is taken.
module double_hash_counting_table #(
  parameter int TABLE_DEPTH = dht_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = dht_pkg::KEY_BITS_DEF,
  parameter int COUNT_BITS  = dht_pkg::COUNT_BITS_DEF,
  localparam int SLOT_W     = $clog2(TABLE_DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input transactions.
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [dht_pkg::OP_W-1:0]    in_opcode,
  input  logic [KEY_BITS-1:0]         in_key,
  // Result transactions.
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [dht_pkg::STAT_W-1:0]  out_status,
  output logic [COUNT_BITS-1:0]       out_vote_count,
  output logic [SLOT_W-1:0]           out_slot,
  output logic                        out_new_entry,
  output logic [dht_pkg::IDX_W-1:0]   out_entry_index,
  // Table size register.
  input  logic                        cfg_wr_en,
  input  logic [dht_pkg::CFG_W-1:0]   cfg_wr_data
);

  // Arithmetic width for sizes and positions: holds the size in use, and the
  // sum of a position and a step, which stays below twice the size.
  localparam int AW     = ((SLOT_W > dht_pkg::CFG_W) ? SLOT_W : dht_pkg::CFG_W) + 1;
  localparam int DATA_W = dht_pkg::MARK_W + KEY_BITS + COUNT_BITS;

  // Control state.
  dht_pkg::dht_state_t state_r, state_nxt;
  logic [dht_pkg::CFG_W-1:0]   cfg_size_r;
  logic [dht_pkg::ENTRY_W-1:0] entry_cnt_r, entry_cnt_nxt;
  logic [SLOT_W-1:0]           clr_addr_r, clr_addr_nxt;
  logic                        out_valid_r, out_valid_nxt;

  // Working registers for the transaction in flight.
  logic [dht_pkg::OP_W-1:0] op_r, op_nxt;
  logic [KEY_BITS-1:0]      key_r, key_nxt;
  logic [AW-1:0]            m_r, m_nxt;
  logic [AW-1:0]            pos_r, pos_nxt;
  logic [AW-1:0]            step_r, step_nxt;
  logic [AW-1:0]            probe_n_r, probe_n_nxt;

  // Pending result, then the output register.
  logic [dht_pkg::STAT_W-1:0] res_status_r, res_status_nxt;
  logic [COUNT_BITS-1:0]      res_votes_r, res_votes_nxt;
  logic [SLOT_W-1:0]          res_slot_r, res_slot_nxt;
  logic                       res_new_r, res_new_nxt;
  logic [dht_pkg::IDX_W-1:0]  res_idx_r, res_idx_nxt;

  logic [dht_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [COUNT_BITS-1:0]      out_votes_r, out_votes_nxt;
  logic [SLOT_W-1:0]          out_slot_r, out_slot_nxt;
  logic                       out_new_r, out_new_nxt;
  logic [dht_pkg::IDX_W-1:0]  out_idx_r, out_idx_nxt;

  // Memory and modulo unit hookup.
  logic              ram_we, ram_re;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;
  logic              mod_start, mod_done;
  logic [AW-1:0]     mod_rem;

  // Combinational helpers.
  logic [AW-1:0]         m_calc;
  logic [AW-1:0]         mm2, home_red, pos_sum, pos_adv;
  dht_pkg::mark_t        rd_mark;
  logic [KEY_BITS-1:0]   rd_key;
  logic [COUNT_BITS-1:0] rd_cnt, cnt_inc;
  logic                  key_hit, last_probe;

  dht_mod_unit #(
    .DIVIDEND_W (KEY_BITS),
    .DIVISOR_W  (AW)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (in_key),
    .divisor   (m_calc),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  dht_slot_ram #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (SLOT_W),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // The size in use is the register clamped to the range three to TABLE_DEPTH.
  always_comb begin
    m_calc = AW'(cfg_size_r);
    if (cfg_size_r < dht_pkg::SIZE_MIN) begin
      m_calc = AW'(dht_pkg::SIZE_MIN);
    end else if (32'(cfg_size_r) > TABLE_DEPTH) begin
      m_calc = AW'(TABLE_DEPTH);
    end
  end

  // Probe step: size - 2 - (home mod (size - 2)). The home slot is below the
  // size, so the inner modulo needs at most two subtractions, and the second
  // one is only reached at the smallest size, where size - 2 is one.
  assign mm2      = m_r - AW'(2);
  assign home_red = (pos_r >= (mm2 + mm2)) ? (pos_r - mm2 - mm2) :
                    (pos_r >= mm2)         ? (pos_r - mm2)       : pos_r;

  // Next position along the chain: position and step are both below the
  // size, so one compare and subtract wraps the sum.
  assign pos_sum = pos_r + step_r;
  assign pos_adv = (pos_sum >= m_r) ? (pos_sum - m_r) : pos_sum;

  // Fields of the slot word read in the previous cycle.
  assign rd_mark = dht_pkg::mark_t'(ram_rdata[DATA_W-1 -: dht_pkg::MARK_W]);
  assign rd_key  = ram_rdata[COUNT_BITS +: KEY_BITS];
  assign rd_cnt  = ram_rdata[COUNT_BITS-1:0];
  assign cnt_inc = (rd_cnt == '1) ? rd_cnt : (rd_cnt + COUNT_BITS'(1));

  assign key_hit    = (rd_mark == dht_pkg::MARK_OCCUPIED) && (rd_key == key_r);
  assign last_probe = (probe_n_r == (m_r - AW'(1)));

  always_comb begin
    state_nxt      = state_r;
    entry_cnt_nxt  = entry_cnt_r;
    clr_addr_nxt   = clr_addr_r;
    out_valid_nxt  = out_valid_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    m_nxt          = m_r;
    pos_nxt        = pos_r;
    step_nxt       = step_r;
    probe_n_nxt    = probe_n_r;
    res_status_nxt = res_status_r;
    res_votes_nxt  = res_votes_r;
    res_slot_nxt   = res_slot_r;
    res_new_nxt    = res_new_r;
    res_idx_nxt    = res_idx_r;
    out_status_nxt = out_status_r;
    out_votes_nxt  = out_votes_r;
    out_slot_nxt   = out_slot_r;
    out_new_nxt    = out_new_r;
    out_idx_nxt    = out_idx_r;
    ram_we         = 1'b0;
    ram_waddr      = pos_r[SLOT_W-1:0];
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = pos_r[SLOT_W-1:0];
    mod_start      = 1'b0;

    // The output register empties when the receiver takes its transaction.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      dht_pkg::S_CLR: begin
        // Sweep every slot to empty after reset.
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
        if (clr_addr_r == SLOT_W'(TABLE_DEPTH - 1)) begin
          state_nxt = dht_pkg::S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + SLOT_W'(1);
        end
      end

      dht_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_opcode;
          key_nxt   = in_key;
          m_nxt     = m_calc;
          mod_start = 1'b1;
          state_nxt = dht_pkg::S_HASH;
        end
      end

      dht_pkg::S_HASH: begin
        if (mod_done) begin
          pos_nxt   = mod_rem;
          state_nxt = dht_pkg::S_STEP;
        end
      end

      dht_pkg::S_STEP: begin
        // Failure result by default; unused fields stay zero.
        res_status_nxt = dht_pkg::ST_MISS;
        res_votes_nxt  = '0;
        res_slot_nxt   = '0;
        res_new_nxt    = 1'b0;
        res_idx_nxt    = '0;
        step_nxt       = mm2 - home_red;
        probe_n_nxt    = '0;
        if ((op_r != dht_pkg::OP_COUNT && op_r != dht_pkg::OP_SEARCH &&
             op_r != dht_pkg::OP_REMOVE) ||
            (op_r != dht_pkg::OP_COUNT && entry_cnt_r == '0)) begin
          // Unused opcode, or a lookup on an empty table.
          state_nxt = dht_pkg::S_OUT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = pos_r[SLOT_W-1:0];
          state_nxt = dht_pkg::S_CHK;
        end
      end

      dht_pkg::S_CHK: begin
        if (op_r == dht_pkg::OP_COUNT && rd_mark != dht_pkg::MARK_OCCUPIED) begin
          // First free slot on the chain takes the new key.
          ram_we         = 1'b1;
          ram_wdata      = {dht_pkg::MARK_OCCUPIED, key_r, COUNT_BITS'(1)};
          res_status_nxt = dht_pkg::ST_OK;
          res_votes_nxt  = COUNT_BITS'(1);
          res_slot_nxt   = pos_r[SLOT_W-1:0];
          res_new_nxt    = 1'b1;
          res_idx_nxt    = entry_cnt_r[dht_pkg::IDX_W-1:0];
          entry_cnt_nxt  = entry_cnt_r + dht_pkg::ENTRY_W'(1);
          state_nxt      = dht_pkg::S_OUT;
        end else if (key_hit) begin
          res_status_nxt = dht_pkg::ST_OK;
          res_slot_nxt   = pos_r[SLOT_W-1:0];
          res_votes_nxt  = rd_cnt;
          state_nxt      = dht_pkg::S_OUT;
          if (op_r == dht_pkg::OP_COUNT) begin
            // Saturating vote increment.
            ram_we        = 1'b1;
            ram_wdata     = {dht_pkg::MARK_OCCUPIED, key_r, cnt_inc};
            res_votes_nxt = cnt_inc;
          end else if (op_r == dht_pkg::OP_REMOVE) begin
            ram_we = 1'b1;
            if (rd_cnt > COUNT_BITS'(1)) begin
              ram_wdata = {dht_pkg::MARK_OCCUPIED, key_r, rd_cnt - COUNT_BITS'(1)};
            end else begin
              // The last vote leaves a removed marker behind.
              ram_wdata     = {dht_pkg::MARK_REMOVED, KEY_BITS'(0), COUNT_BITS'(0)};
              entry_cnt_nxt = entry_cnt_r - dht_pkg::ENTRY_W'(1);
            end
          end
        end else if (op_r != dht_pkg::OP_COUNT && rd_mark == dht_pkg::MARK_EMPTY) begin
          // An empty slot ends the search.
          state_nxt = dht_pkg::S_OUT;
        end else if (last_probe) begin
          // The whole chain was walked.
          res_status_nxt = (op_r == dht_pkg::OP_COUNT) ? dht_pkg::ST_FULL
                                                       : dht_pkg::ST_MISS;
          state_nxt      = dht_pkg::S_OUT;
        end else begin
          pos_nxt     = pos_adv;
          probe_n_nxt = probe_n_r + AW'(1);
          ram_re      = 1'b1;
          ram_raddr   = pos_adv[SLOT_W-1:0];
        end
      end

      dht_pkg::S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_votes_nxt  = res_votes_r;
          out_slot_nxt   = res_slot_r;
          out_new_nxt    = res_new_r;
          out_idx_nxt    = res_idx_r;
          state_nxt      = dht_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = dht_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dht_pkg::S_CLR;
      cfg_size_r  <= dht_pkg::SIZE_RESET;
      entry_cnt_r <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      entry_cnt_r <= entry_cnt_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_size_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    m_r          <= m_nxt;
    pos_r        <= pos_nxt;
    step_r       <= step_nxt;
    probe_n_r    <= probe_n_nxt;
    res_status_r <= res_status_nxt;
    res_votes_r  <= res_votes_nxt;
    res_slot_r   <= res_slot_nxt;
    res_new_r    <= res_new_nxt;
    res_idx_r    <= res_idx_nxt;
    out_status_r <= out_status_nxt;
    out_votes_r  <= out_votes_nxt;
    out_slot_r   <= out_slot_nxt;
    out_new_r    <= out_new_nxt;
    out_idx_r    <= out_idx_nxt;
  end

  assign in_stall        = (state_r != dht_pkg::S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_vote_count  = out_votes_r;
  assign out_slot        = out_slot_r;
  assign out_new_entry   = out_new_r;
  assign out_entry_index = out_idx_r;

endmodule
